// ===== src/tst_pkg.sv =====
// Shared types, operation codes and constants of the timer slot table.
package tst_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 8;

    localparam logic [63:0] RESET_STEP = 64'd1000000;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_CANCEL   = 3'd2;
    localparam logic [2:0] OP_QUERY    = 3'd3;
    localparam logic [2:0] OP_INIT     = 3'd4;
    localparam logic [2:0] OP_SHUTDOWN = 3'd5;

    localparam int TDATA_BITS = 208;

    typedef struct packed {
        logic capture;
        logic tick_upd;
        logic do_init;
        logic do_shut;
        logic free_clr;
        logic rd;
        logic drop;
        logic note_free;
        logic retire;
        logic rem_start;
        logic dl_write;
        logic alloc;
        logic emit_exp;
        logic emit_stat;
    } tst_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ready;
        logic       used;
        logic       due;
        logic       match;
        logic       per;
        logic       rem_done;
        logic       found;
        logic       out_free;
    } tst_sts_t;

endpackage

// ===== src/tst_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
module tst_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] rem
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    assign trial = {rem_reg, dvd_reg[63]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            div_next = divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = 64'(trial - {1'b0, div_reg});
            else
                rem_next = trial[63:0];
            dvd_next = {dvd_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/tst_datapath.sv =====
// Datapath: clock registers, slot storage, deadline advance and output register.
module tst_datapath #(
    parameter int SLOTS       = tst_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = tst_pkg::HANDLE_BITS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int HW = (HANDLE_BITS < 8) ? HANDLE_BITS : 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tst_pkg::tst_cmd_t          cmd,
    input  logic [IW-1:0]              idx,
    output tst_pkg::tst_sts_t          sts,
    input  logic [tst_pkg::TDATA_BITS-1:0] in_data,
    input  logic [2:0]                 in_op,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tst_pkg::TDATA_BITS-1:0] out_data,
    output logic                       out_kind,
    output logic                       out_last
);

    // Captured input word.
    logic [2:0]    op_reg;
    logic [63:0]   delta_reg, delay_reg, iv_reg;
    logic [HW-1:0] h_reg;
    logic          per_reg;

    // Clock state.
    logic [63:0] now_reg, now_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [63:0] fine_reg, fine_next;
    logic        ready_reg, ready_next;
    logic [SLOTS-1:0] used_reg, used_next;

    // Free slot tracking for start.
    logic          found_reg, found_next;
    logic [IW-1:0] free_idx_reg;

    // Slot memory and its registered read port.
    logic [HW-1:0] mem_h   [SLOTS];
    logic [63:0]   mem_dl  [SLOTS];
    logic [63:0]   mem_iv  [SLOTS];
    logic          mem_per [SLOTS];
    logic [HW-1:0] rd_h;
    logic [63:0]   rd_dl, rd_iv;
    logic          rd_per;

    // Remainder unit and deadline advance.
    logic        rem_done;
    logic [63:0] rem;
    logic [63:0] gap;
    logic [64:0] step_sum;
    logic [63:0] new_dl;

    // Output register.
    logic        ov_reg, ov_next;
    logic        okind_reg, olast_reg;
    logic [tst_pkg::TDATA_BITS-1:0] odata_reg;
    logic        out_free;
    logic        stat_bit;

    assign gap      = now_reg - rd_dl;
    assign step_sum = {1'b0, gap} + {1'b0, 64'(rd_iv - rem)};
    assign new_dl   = (step_sum > {1'b0, ~rd_dl}) ? '1 : 64'(now_reg - rem + rd_iv);

    tst_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (gap),
        .divisor  (rd_iv),
        .done     (rem_done),
        .rem      (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            delta_reg <= in_data[63:0];
            h_reg     <= in_data[64 +: HW];
            delay_reg <= in_data[135:72];
            iv_reg    <= in_data[199:136];
            per_reg   <= in_data[200];
        end
    end

    always_comb
    begin
        now_next   = now_reg;
        cnt_next   = cnt_reg;
        fine_next  = fine_reg;
        ready_next = ready_reg;
        used_next  = used_reg;
        found_next = found_reg;
        if (cmd.tick_upd)
        begin
            now_next = now_reg + delta_reg;
            cnt_next = cnt_reg + 64'd1;
            if (delta_reg != 64'd0 && (fine_reg == 64'd0 || delta_reg < fine_reg))
                fine_next = delta_reg;
        end
        if (cmd.do_init)
        begin
            now_next   = '0;
            cnt_next   = '0;
            fine_next  = tst_pkg::RESET_STEP;
            used_next  = '0;
            ready_next = 1'b1;
        end
        if (cmd.do_shut)
        begin
            used_next  = '0;
            ready_next = 1'b0;
        end
        if (cmd.drop || cmd.retire)
            used_next[idx] = 1'b0;
        if (cmd.free_clr)
            found_next = 1'b0;
        if (cmd.note_free)
            found_next = 1'b1;
        if (cmd.alloc && found_reg)
            used_next[free_idx_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            cnt_reg   <= '0;
            fine_reg  <= tst_pkg::RESET_STEP;
            ready_reg <= 1'b1;
            used_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            now_reg   <= now_next;
            cnt_reg   <= cnt_next;
            fine_reg  <= fine_next;
            ready_reg <= ready_next;
            used_reg  <= used_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.note_free && !found_reg)
            free_idx_reg <= idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc && found_reg)
        begin
            mem_h[free_idx_reg]   <= h_reg;
            mem_dl[free_idx_reg]  <= now_reg + delay_reg;
            mem_iv[free_idx_reg]  <= iv_reg;
            mem_per[free_idx_reg] <= per_reg;
        end
        else if (cmd.dl_write)
        begin
            mem_dl[idx] <= new_dl;
        end
        if (cmd.rd)
        begin
            rd_h   <= mem_h[idx];
            rd_dl  <= mem_dl[idx];
            rd_iv  <= mem_iv[idx];
            rd_per <= mem_per[idx];
        end
    end

    // A status word reports a failed start when no slot was free.
    assign stat_bit = (op_reg == tst_pkg::OP_START) && !found_reg;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.emit_exp || cmd.emit_stat)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_exp || cmd.emit_stat)
        begin
            okind_reg <= cmd.emit_exp;
            olast_reg <= cmd.emit_stat;
            odata_reg <= {7'd0, fine_next, cnt_next, now_next,
                          cmd.emit_exp ? 8'(rd_h) : 8'd0,
                          cmd.emit_exp ? 1'b0 : stat_bit};
        end
    end

    assign sts.op       = op_reg;
    assign sts.ready    = ready_reg;
    assign sts.used     = used_reg[idx];
    assign sts.due      = (rd_dl <= now_reg);
    assign sts.match    = (rd_h == h_reg);
    assign sts.per      = rd_per && (rd_iv != 64'd0);
    assign sts.rem_done = rem_done;
    assign sts.found    = found_reg;
    assign sts.out_free = out_free;

    assign out_valid = ov_reg;
    assign out_data  = odata_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;

endmodule

// ===== src/tst_ctrl.sv =====
// Controller: sequences each operation over the slot table.
module tst_ctrl #(
    parameter int SLOTS = tst_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tst_pkg::tst_sts_t sts,
    output tst_pkg::tst_cmd_t cmd,
    output logic [IW-1:0]     idx
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EV    = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_ALLOC = 3'd6;
    localparam logic [2:0] S_STAT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          last_slot;
    logic [2:0]    after_scan;

    assign last_slot  = (idx_reg == IW'(SLOTS - 1));
    assign after_scan = (sts.op == tst_pkg::OP_START) ? S_ALLOC : S_STAT;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next   = '0;
                state_next = S_STAT;
                priority case (sts.op)
                    tst_pkg::OP_TICK:
                    begin
                        if (sts.ready)
                        begin
                            cmd.tick_upd = 1'b1;
                            state_next   = S_RD;
                        end
                    end
                    tst_pkg::OP_START, tst_pkg::OP_CANCEL:
                    begin
                        cmd.free_clr = 1'b1;
                        state_next   = S_RD;
                    end
                    tst_pkg::OP_INIT:     cmd.do_init = 1'b1;
                    tst_pkg::OP_SHUTDOWN: cmd.do_shut = 1'b1;
                    default: ;
                endcase
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                if (sts.op == tst_pkg::OP_TICK && sts.used && sts.due)
                begin
                    if (sts.per)
                    begin
                        cmd.rem_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.retire = 1'b1;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    if (sts.op != tst_pkg::OP_TICK)
                    begin
                        cmd.drop      = sts.used && sts.match;
                        cmd.note_free = !sts.used || sts.match;
                    end
                    if (last_slot)
                        state_next = after_scan;
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.rem_done)
                begin
                    cmd.dl_write = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_exp = 1'b1;
                    if (last_slot)
                        state_next = S_STAT;
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_STAT;
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_stat = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

// ===== src/timer_slot_table.sv =====
// Top level of the timer slot table: controller, datapath and stream ports.
//
// The block keeps a 64-bit nanosecond clock and a table of SLOTS timers.
// One command word enters on the s_axis channel; the operation code rides
// in s_axis_tuser. Every command produces one status word on m_axis with
// m_axis_tlast high, and a tick first produces one expiry word (tuser high)
// for each timer that fires, in slot order.
// Commands are taken one at a time; s_axis_tready is high only while the
// block waits for the next command. Query, init and shutdown pass from
// the dispatch state straight to the status state, which registers the
// status word once the output register is free. Cancel and start walk
// the table, reading and checking each slot in turn, and start then
// fills the free slot. A tick, while ticks are enabled, also walks the
// table, emitting an expiry word for each fired timer; a periodic timer
// first has its catch-up run through the bit-serial remainder unit.
// Results sit in an output register; while the receiver holds
// m_axis_tready low the walk pauses at the next word to be sent.
// Reset puts the block in the state after init: clock and tick count zero,
// finest step one millisecond, all slots free, ticks enabled.
module timer_slot_table #(
    parameter int SLOTS       = tst_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = tst_pkg::HANDLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // delta_ns[63:0], timer_handle[71:64], first expiry delay[135:72],
    // repeat interval[199:136], periodic[200], zero pad to 208 bits.
    input  logic [207:0] s_axis_tdata,
    // operation[2:0].
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0], fired_handle[8:1], now_ns[72:9], tick_total[136:73],
    // finest_step_ns[200:137], zero pad to 208 bits.
    output logic [207:0] m_axis_tdata,
    // kind[0].
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tst_pkg::tst_cmd_t cmd;
    tst_pkg::tst_sts_t sts;
    logic [IW-1:0]     idx;
    logic              kind;

    tst_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .idx      (idx)
    );

    tst_datapath #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (kind),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = kind;

endmodule

// ===== src/tst_checker.sv =====
// Port-level checks of the timer slot table's result stream.
module tst_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [207:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
        else $error("expiry word marked last");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[0])
        else $error("expiry word carries a failure status");

    a_status_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[8:1] == 8'd0 && m_axis_tlast)
        else $error("status word malformed");

endmodule

bind timer_slot_table tst_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
